// ----- hw/rtl/plist_pkg.sv -----
`timescale 1ns / 1ps

package plist_pkg;

    // Field widths fixed by the interface
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned LENGTH_W = 5;

    // Command codes
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_OOB   = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // What one cell loads on the next clock
    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_LEFT  = 3'd2,
        OP_RIGHT = 3'd3,
        OP_HEAD  = 3'd4
    } cell_op_t;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

endpackage

// ----- hw/rtl/plist_cell.sv -----
`timescale 1ns / 1ps

module plist_cell (
    input  logic                                    clk,
    input  plist_pkg::cell_op_t                     op,
    input  logic signed [plist_pkg::DATA_W-1:0]     load_value,
    input  logic signed [plist_pkg::DATA_W-1:0]     left_q,
    input  logic signed [plist_pkg::DATA_W-1:0]     right_q,
    input  logic signed [plist_pkg::DATA_W-1:0]     head_q,
    output logic signed [plist_pkg::DATA_W-1:0]     q
);
    import plist_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // Pick the new content: hold, take the item value, a neighbor, or the head cell
    always_comb
    begin
        unique case (op)
            OP_LOAD:  data_next = load_value;
            OP_LEFT:  data_next = left_q;
            OP_RIGHT: data_next = right_q;
            OP_HEAD:  data_next = head_q;
            default:  data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ----- hw/rtl/positional_list_insert_delete_core.sv -----
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in        in_valid / in_ready   cmd, value, position
// out       out_valid / out_ready status, element, element_valid, length, last
//
// Append, insert and delete update the row directly: every cell shifts or loads in
// parallel and one result goes to the output register. A read-out first moves to
// the read state without a result (an empty list returns STAT_EMPTY), then the
// head cell is sent out and the occupied cells rotate one place toward the
// head each unstalled cycle, so the list is back in order after the last
// element. A stalled output holds the rotation and the input. Reset clears the
// element count; cell contents are not reset.

module positional_list_insert_delete_core #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [1:0]                              cmd,
    input  logic signed [plist_pkg::DATA_W-1:0]     value,
    input  logic [plist_pkg::POS_W-1:0]             position,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [1:0]                              status,
    output logic signed [plist_pkg::DATA_W-1:0]     element,
    output logic                                    element_valid,
    output logic [plist_pkg::LENGTH_W-1:0]          length,
    output logic                                    last
);
    import plist_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Control state
    state_t          state_reg,  state_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic [CW-1:0]   rd_left_reg, rd_left_next;

    // Output register
    logic                     out_valid_reg,  out_valid_next;
    status_t                  status_reg,     status_next;
    logic signed [DATA_W-1:0] element_reg,    element_next;
    logic                     elem_vld_reg,   elem_vld_next;
    logic [LENGTH_W-1:0]      length_reg,     length_next;
    logic                     last_reg,       last_next;

    // Decode
    cmd_t             cmd_sel;
    logic             accept;
    logic             slot_free;
    logic             rotate;
    logic             empty;
    logic             full;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] eff_idx;
    logic [POS_W-1:0] cnt7;
    logic             in_range;
    logic             do_append;
    logic             do_insert;
    logic             do_delete;

    logic signed [DATA_W-1:0] cell_q [DEPTH];
    cell_op_t                 cell_op [DEPTH];

    assign cmd_sel   = cmd_t'(cmd);
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign rotate    = (state_reg == S_READ) && slot_free;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign idx      = (position == '0) ? '0 : position - POS_W'(1);
    assign eff_idx  = empty ? '0 : idx;
    assign cnt7     = POS_W'(count_reg);
    assign in_range = idx < cnt7;

    assign do_append = accept && (cmd_sel == CMD_APPEND) && !full;
    assign do_insert = accept && (cmd_sel == CMD_INSERT) && !full && (empty || in_range);
    assign do_delete = accept && (cmd_sel == CMD_DELETE) && !empty && in_range;

    // Row of cells with per-cell control
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_q;
        logic signed [DATA_W-1:0] right_q;

        if (i == 0)
        begin : g_head
            assign left_q = '0;
        end
        else
        begin : g_mid_l
            assign left_q = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_q = cell_q[i];
        end
        else
        begin : g_mid_r
            assign right_q = cell_q[i+1];
        end

        // Choose the move for this cell
        always_comb
        begin
            cell_op[i] = OP_HOLD;
            if (do_append)
            begin
                if (POS_W'(i) == cnt7)
                    cell_op[i] = OP_LOAD;
            end
            else if (do_insert)
            begin
                if (POS_W'(i) == eff_idx)
                    cell_op[i] = OP_LOAD;
                else if ((POS_W'(i) > eff_idx) && (POS_W'(i) <= cnt7))
                    cell_op[i] = OP_LEFT;
            end
            else if (do_delete)
            begin
                if ((POS_W'(i) >= idx) && (POS_W'(i) + POS_W'(1) < cnt7))
                    cell_op[i] = OP_RIGHT;
            end
            else if (rotate)
            begin
                if (POS_W'(i) + POS_W'(1) < cnt7)
                    cell_op[i] = OP_RIGHT;
                else if (POS_W'(i) + POS_W'(1) == cnt7)
                    cell_op[i] = OP_HEAD;
            end
        end

        plist_cell u_cell (
            .clk        (clk),
            .op         (cell_op[i]),
            .load_value (value),
            .left_q     (left_q),
            .right_q    (right_q),
            .head_q     (cell_q[0]),
            .q          (cell_q[i])
        );
    end

    // Sequencer, count and output register
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_left_next   = rd_left_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        element_next   = element_reg;
        elem_vld_next  = elem_vld_reg;
        length_next    = length_reg;
        last_next      = last_reg;

        if (do_append || do_insert)
            count_next = count_reg + CW'(1);
        else if (do_delete)
            count_next = count_reg - CW'(1);

        if (accept)
        begin
            out_valid_next = 1'b1;
            element_next   = '0;
            elem_vld_next  = 1'b0;
            last_next      = 1'b1;
            length_next    = LENGTH_W'(count_next);
            unique case (cmd_sel)
                CMD_APPEND:
                    status_next = full ? STAT_FULL : STAT_OK;
                CMD_INSERT:
                begin
                    priority if (full)
                        status_next = STAT_FULL;
                    else if (empty || in_range)
                        status_next = STAT_OK;
                    else
                        status_next = STAT_OOB;
                end
                CMD_DELETE:
                begin
                    priority if (empty)
                        status_next = STAT_EMPTY;
                    else if (in_range)
                        status_next = STAT_OK;
                    else
                        status_next = STAT_OOB;
                end
                default:
                begin
                    if (empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        // Start the read-out; the first element is sent from the read state
                        out_valid_next = 1'b0;
                        state_next     = S_READ;
                        rd_left_next   = count_reg;
                    end
                end
            endcase
        end
        else if (rotate)
        begin
            // Send the head element and advance the rotation
            out_valid_next = 1'b1;
            status_next    = STAT_OK;
            element_next   = cell_q[0];
            elem_vld_next  = 1'b1;
            length_next    = LENGTH_W'(count_reg);
            last_next      = (rd_left_reg == CW'(1));
            rd_left_next   = rd_left_reg - CW'(1);
            if (rd_left_reg == CW'(1))
                state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_left_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_left_reg   <= rd_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        element_reg  <= element_next;
        elem_vld_reg <= elem_vld_next;
        length_reg   <= length_next;
        last_reg     <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign element       = element_reg;
    assign element_valid = elem_vld_reg;
    assign length        = length_reg;
    assign last          = last_reg;

endmodule
